// ===== rtl/lgs_pkg.sv =====
// Shared types and constants for the LDA Gibbs topic sampler.
// No dependencies; used by every module of the sampler.
package lgs_pkg;

  // Operation codes carried by an input transaction
  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_ADD_DOC   = 2'd1,
    OP_ADD_MODEL = 2'd2,
    OP_SAMPLE    = 2'd3
  } opcode_t;

  // Configuration register indexes
  localparam logic [1:0] REG_ALPHA  = 2'd0;
  localparam logic [1:0] REG_BETA   = 2'd1;
  localparam logic [1:0] REG_BTOTAL = 2'd2;
  localparam logic [1:0] REG_ACTIVE = 2'd3;

  // Register reset values
  localparam logic [31:0] ALPHA_RST  = 32'd6554;
  localparam logic [31:0] BETA_RST   = 32'd655;
  localparam logic [31:0] BTOTAL_RST = 32'd655360;
  localparam logic [6:0]  ACTIVE_RST = 7'd64;

  localparam int CFG_W    = 32;
  localparam int WEIGHT_W = 48;
  localparam int RAND_W   = 24;
  localparam int DOC_W    = 16;
  localparam int DIGIT_W  = 16;

  typedef struct packed {
    opcode_t     opcode;
    logic [11:0] word_index;
    logic [5:0]  topic_index;
    logic [23:0] random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [5:0] new_topic;
    logic       topic_changed;
  } out_item_t;

  // Count store access strobes
  typedef struct packed {
    logic wt_rd;
    logic wt_wr;
    logic tt_rd;
    logic tt_wr;
    logic dc_rd;
    logic dc_wr;
    logic dc_clear;
  } store_ctrl_t;

endpackage

// ===== rtl/lgs_divider.sv =====
// Iterative restoring divider: 48-bit saturated quotient, one bit a cycle.
// Depends on lgs_pkg for the weight width.
module lgs_divider #(
  parameter int NUM_W = 98,
  parameter int DEN_W = 49
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [NUM_W-1:0]              num,
  input  logic [DEN_W-1:0]              den,
  output logic                          done,
  output logic [lgs_pkg::WEIGHT_W-1:0]  quot
);
  localparam int QW   = lgs_pkg::WEIGHT_W;
  localparam int HI_W = NUM_W - QW;
  localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int CNT_W = $clog2(QW);

  logic                 running_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DEN_W-1:0]     rem_r;
  logic [QW-1:0]        lo_r;
  logic [QW-1:0]        q_r;
  logic [DEN_W:0]       trial;
  logic                 fits;
  logic                 sat;

  // one quotient bit per cycle
  assign trial = {rem_r, lo_r[QW-1]};
  assign fits  = trial >= {1'b0, den};
  assign sat   = CW'(num[NUM_W-1:QW]) >= CW'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        cnt_r <= '0;
        if (sat) begin
          q_r    <= '1;
          done_r <= 1'b1;
        end else begin
          rem_r     <= DEN_W'(num[NUM_W-1:QW]);
          lo_r      <= num[QW-1:0];
          q_r       <= '0;
          running_r <= 1'b1;
        end
      end else if (running_r) begin
        lo_r <= {lo_r[QW-2:0], 1'b0};
        if (fits) begin
          rem_r <= DEN_W'(trial - {1'b0, den});
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= trial[DEN_W-1:0];
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
        cnt_r <= CNT_W'(cnt_r + 1'b1);
        if (cnt_r == CNT_W'(QW - 1)) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/lgs_count_store.sv =====
// Count memories: word-topic counts, topic totals and document counts.
// Depends on lgs_pkg; clears the model memories by a sweep after reset.
module lgs_count_store #(
  parameter int MAX_TOPICS = 64,
  parameter int VOCAB_SIZE = 4096,
  parameter int COUNT_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lgs_pkg::store_ctrl_t                   ctrl,
  input  logic [$clog2(VOCAB_SIZE*MAX_TOPICS)-1:0] wt_addr,
  input  logic [$clog2(MAX_TOPICS)-1:0]          tp_addr,
  input  logic [COUNT_BITS-1:0]                  wt_wdata,
  input  logic [COUNT_BITS-1:0]                  tt_wdata,
  input  logic [lgs_pkg::DOC_W-1:0]              dc_wdata,
  output logic [COUNT_BITS-1:0]                  wt_rdata,
  output logic [COUNT_BITS-1:0]                  tt_rdata,
  output logic [lgs_pkg::DOC_W-1:0]              dc_rdata,
  output logic                                   clearing
);
  localparam int DEPTH = VOCAB_SIZE * MAX_TOPICS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(MAX_TOPICS);

  logic [COUNT_BITS-1:0]     wt_mem [DEPTH];
  logic [COUNT_BITS-1:0]     tt_mem [MAX_TOPICS];
  logic [lgs_pkg::DOC_W-1:0] dc_mem [MAX_TOPICS];

  logic [MAX_TOPICS-1:0]     dc_valid_r;
  logic                      clearing_r;
  logic [AW-1:0]             clr_r;
  logic [COUNT_BITS-1:0]     wt_q_r;
  logic [COUNT_BITS-1:0]     tt_q_r;
  logic [lgs_pkg::DOC_W-1:0] dc_q_r;
  logic                      dc_v_r;
  logic [TW-1:0]             clr_tp;

  assign clr_tp = clr_r[TW-1:0];

  // clearing sweep state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= AW'(clr_r + 1'b1);
      if (clr_r == AW'(DEPTH - 1)) clearing_r <= 1'b0;
    end
  end

  // word-topic memory
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      wt_mem[clr_r] <= '0;
    end else if (ctrl.wt_wr) begin
      wt_mem[wt_addr] <= wt_wdata;
    end
    if (ctrl.wt_rd) wt_q_r <= wt_mem[wt_addr];
  end

  // topic totals
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      if (32'(clr_tp) < MAX_TOPICS) tt_mem[clr_tp] <= '0;
    end else if (ctrl.tt_wr) begin
      tt_mem[tp_addr] <= tt_wdata;
    end
    if (ctrl.tt_rd) tt_q_r <= tt_mem[tp_addr];
  end

  // document counts, with per-entry valid bits so that one strobe clears every entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_valid_r <= '0;
    end else if (ctrl.dc_clear) begin
      dc_valid_r <= '0;
    end else if (ctrl.dc_wr) begin
      dc_valid_r[tp_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.dc_wr) dc_mem[tp_addr] <= dc_wdata;
    if (ctrl.dc_rd) begin
      dc_q_r <= dc_mem[tp_addr];
      dc_v_r <= dc_valid_r[tp_addr];
    end
  end

  assign wt_rdata = wt_q_r;
  assign tt_rdata = tt_q_r;
  assign dc_rdata = dc_v_r ? dc_q_r : '0;
  assign clearing = clearing_r;

endmodule

// ===== rtl/lda_gibbs_topic_sampler.sv =====
// Top level of the LDA collapsed Gibbs topic sampler.
// Depends on lgs_pkg, lgs_count_store and lgs_divider.
//
//  channel   ports                       transaction at
//  input     start, busy, in_data        rising edge, start high and busy low
//  result    out_valid, out_data         the single cycle out_valid is high
//  config    cfg_we, cfg_index, cfg_wdata rising edge with cfg_we high
//
// A sample walks the n active topics, running a digit-serial multiply over
// ND = ceil(CT_W/16) digits (4 at defaults) and the bit-serial divider for
// each topic; clear and add opcodes skip that walk. After reset the model
// memories are swept with busy high; config writes are taken meanwhile.
// Results cannot be stalled by the receiver.
module lda_gibbs_topic_sampler #(
  parameter int MAX_TOPICS = 64,
  parameter int VOCAB_SIZE = 4096,
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lgs_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output lgs_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]     cfg_wdata
);
  localparam int TW     = $clog2(MAX_TOPICS);
  localparam int NW     = $clog2(MAX_TOPICS + 1);
  localparam int AW     = $clog2(VOCAB_SIZE * MAX_TOPICS);
  localparam int DW16   = lgs_pkg::DIGIT_W;
  localparam int DT_W   = (((lgs_pkg::DOC_W + FRAC_BITS) > 32) ?
                           (lgs_pkg::DOC_W + FRAC_BITS) : 32) + 1;
  localparam int CT_W   = (((COUNT_BITS + FRAC_BITS) > 32) ?
                           (COUNT_BITS + FRAC_BITS) : 32) + 1;
  localparam int PW     = DT_W + CT_W;
  localparam int ND     = (CT_W + DW16 - 1) / DW16;
  localparam int WPAD_W = ND * DW16;
  localparam int SUM_W  = lgs_pkg::WEIGHT_W + TW;
  localparam int SND    = (SUM_W + DW16 - 1) / DW16;
  localparam int SPAD_W = SND * DW16;
  localparam int TG_W   = SUM_W + lgs_pkg::RAND_W;
  localparam int MC_W   = 3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_TERM, ST_MUL, ST_DGO, ST_DIV,
    ST_TGT, ST_SRD, ST_SCMP, ST_ADJ_RD, ST_ADJ_WR
  } state_t;

  state_t                    state_r;
  logic [31:0]               alpha_r, beta_r, btot_r;
  logic [6:0]                active_r;
  logic [11:0]               word_r;
  logic [5:0]                topic_r;
  logic [lgs_pkg::RAND_W-1:0] frac_r;
  logic                      word_ok_r, topic_ok_r;
  logic [NW-1:0]             n_eff_r, t_r, s_r;
  logic [DT_W-1:0]           dt_r;
  logic [CT_W-1:0]           ts_r;
  logic [WPAD_W-1:0]         wt_sh_r;
  logic [PW-1:0]             acc_r;
  logic [MC_W-1:0]           mcnt_r;
  logic [SUM_W-1:0]          sum_r;
  logic [SPAD_W-1:0]         sum_sh_r;
  logic [TG_W-1:0]           tgt_r;
  logic [SUM_W-1:0]          rs_mem [MAX_TOPICS];
  logic [SUM_W-1:0]          rs_q_r;
  logic [TW-1:0]             res_r, adj_topic_r;
  logic                      adj_inc_r, adj_wt_r, adj_tt_r, adj_dc_r, adj_next_r;
  logic [5:0]                out_topic_r;
  logic                      changed_r;
  logic                      out_valid_r;
  lgs_pkg::out_item_t        out_data_r;

  logic                      accept, clearing, dv_done;
  logic [lgs_pkg::WEIGHT_W-1:0] dv_quot;
  lgs_pkg::store_ctrl_t      st_ctrl;
  logic [AW-1:0]             wt_addr;
  logic [TW-1:0]             tp_addr, tp_sel;
  logic [COUNT_BITS-1:0]     wt_rdata, tt_rdata, wt_wdata, tt_wdata;
  logic [lgs_pkg::DOC_W-1:0] dc_rdata, dc_wdata;
  logic [NW-1:0]             n_eff;
  logic [DT_W-1:0]           dt_raw, dt_term;
  logic [CT_W-1:0]           wt_raw, wt_term, ts_raw, ts_term, one_ct;
  logic [DT_W-1:0]           one_dt;
  logic                      red;
  logic [SUM_W-1:0]          sum_nxt;
  logic                      hit, moved;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE) || clearing;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= lgs_pkg::ALPHA_RST;
      beta_r   <= lgs_pkg::BETA_RST;
      btot_r   <= lgs_pkg::BTOTAL_RST;
      active_r <= lgs_pkg::ACTIVE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lgs_pkg::REG_ALPHA:  alpha_r  <= cfg_wdata;
        lgs_pkg::REG_BETA:   beta_r   <= cfg_wdata;
        lgs_pkg::REG_BTOTAL: btot_r   <= cfg_wdata;
        lgs_pkg::REG_ACTIVE: active_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // active topic count clamped to 1..MAX_TOPICS
  always_comb begin
    if (active_r == '0) n_eff = NW'(1);
    else if (32'(active_r) > MAX_TOPICS) n_eff = NW'(MAX_TOPICS);
    else n_eff = NW'(active_r);
  end

  // store addressing: sample loop walks t, adjust uses its own topic
  assign tp_sel  = (state_r == ST_RD) ? t_r[TW-1:0] : adj_topic_r;
  assign tp_addr = tp_sel;
  assign wt_addr = AW'(AW'(word_r) * AW'(MAX_TOPICS) + AW'(tp_sel));

  // read-modify-write data, saturating both ways
  always_comb begin
    if (adj_inc_r) begin
      wt_wdata = (wt_rdata == '1) ? wt_rdata : COUNT_BITS'(wt_rdata + 1'b1);
      tt_wdata = (tt_rdata == '1) ? tt_rdata : COUNT_BITS'(tt_rdata + 1'b1);
      dc_wdata = (dc_rdata == '1) ? dc_rdata : lgs_pkg::DOC_W'(dc_rdata + 1'b1);
    end else begin
      wt_wdata = (wt_rdata == '0) ? wt_rdata : COUNT_BITS'(wt_rdata - 1'b1);
      tt_wdata = (tt_rdata == '0) ? tt_rdata : COUNT_BITS'(tt_rdata - 1'b1);
      dc_wdata = (dc_rdata == '0) ? dc_rdata : lgs_pkg::DOC_W'(dc_rdata - 1'b1);
    end
  end

  // store strobes decoded from state
  always_comb begin
    st_ctrl          = '0;
    st_ctrl.dc_clear = accept && (in_data.opcode == lgs_pkg::OP_CLEAR);
    unique case (state_r)
      ST_RD, ST_ADJ_RD: begin
        st_ctrl.wt_rd = 1'b1;
        st_ctrl.tt_rd = 1'b1;
        st_ctrl.dc_rd = 1'b1;
      end
      ST_ADJ_WR: begin
        st_ctrl.wt_wr = adj_wt_r;
        st_ctrl.tt_wr = adj_tt_r;
        st_ctrl.dc_wr = adj_dc_r;
      end
      default: ;
    endcase
  end

  // the three terms of a topic's weight, old topic reduced by one
  always_comb begin
    one_dt  = DT_W'(1) << FRAC_BITS;
    one_ct  = CT_W'(1) << FRAC_BITS;
    red     = 32'(t_r) == 32'(topic_r);
    dt_raw  = DT_W'((DT_W'(dc_rdata) << FRAC_BITS) + DT_W'(alpha_r));
    wt_raw  = CT_W'(((word_ok_r ? CT_W'(wt_rdata) : '0) << FRAC_BITS) + CT_W'(beta_r));
    ts_raw  = CT_W'((CT_W'(tt_rdata) << FRAC_BITS) + CT_W'(btot_r));
    dt_term = dt_raw;
    wt_term = wt_raw;
    ts_term = ts_raw;
    if (red) begin
      dt_term = (dt_raw >= one_dt) ? DT_W'(dt_raw - one_dt) : '0;
      wt_term = (wt_raw >= one_ct) ? CT_W'(wt_raw - one_ct) : '0;
      ts_term = (ts_raw >= one_ct) ? CT_W'(ts_raw - one_ct) : '0;
    end
    if (ts_term == '0) ts_term = CT_W'(1);
  end

  assign sum_nxt = SUM_W'(sum_r + SUM_W'(dv_quot));
  assign hit     = {rs_q_r, {lgs_pkg::RAND_W{1'b0}}} >= tgt_r;
  assign moved   = 32'(s_r) != 32'(topic_r);

  // running sums memory
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && dv_done) rs_mem[t_r[TW-1:0]] <= sum_nxt;
    if (state_r == ST_SRD) rs_q_r <= rs_mem[s_r[TW-1:0]];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            word_r      <= in_data.word_index;
            topic_r     <= in_data.topic_index;
            frac_r      <= in_data.random_fraction;
            word_ok_r   <= 32'(in_data.word_index) < VOCAB_SIZE;
            topic_ok_r  <= 32'(in_data.topic_index) < MAX_TOPICS;
            out_topic_r <= in_data.topic_index;
            changed_r   <= 1'b0;
            adj_topic_r <= TW'(in_data.topic_index);
            adj_inc_r   <= 1'b1;
            adj_next_r  <= 1'b0;
            unique case (in_data.opcode)
              lgs_pkg::OP_SAMPLE: begin
                t_r     <= '0;
                sum_r   <= '0;
                n_eff_r <= n_eff;
                state_r <= ST_RD;
              end
              lgs_pkg::OP_ADD_DOC, lgs_pkg::OP_ADD_MODEL: begin
                adj_wt_r <= (in_data.opcode == lgs_pkg::OP_ADD_MODEL) &&
                            (32'(in_data.word_index) < VOCAB_SIZE);
                adj_tt_r <= in_data.opcode == lgs_pkg::OP_ADD_MODEL;
                adj_dc_r <= in_data.opcode == lgs_pkg::OP_ADD_DOC;
                if (32'(in_data.topic_index) < MAX_TOPICS) begin
                  state_r <= ST_ADJ_RD;
                end else begin
                  out_data_r  <= '{new_topic: in_data.topic_index, topic_changed: 1'b0};
                  out_valid_r <= 1'b1;
                end
              end
              default: begin
                out_data_r  <= '{new_topic: in_data.topic_index, topic_changed: 1'b0};
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        ST_RD: state_r <= ST_TERM;
        ST_TERM: begin
          dt_r    <= dt_term;
          wt_sh_r <= WPAD_W'(wt_term);
          ts_r    <= ts_term;
          acc_r   <= '0;
          mcnt_r  <= '0;
          state_r <= ST_MUL;
        end
        // product dt*wt, one 16-bit digit of wt a cycle, top digit first
        ST_MUL: begin
          acc_r   <= PW'((acc_r << DW16) + PW'(dt_r * wt_sh_r[WPAD_W-1 -: DW16]));
          wt_sh_r <= WPAD_W'(wt_sh_r << DW16);
          mcnt_r  <= MC_W'(mcnt_r + 1'b1);
          if (mcnt_r == MC_W'(ND - 1)) state_r <= ST_DGO;
        end
        ST_DGO: state_r <= ST_DIV;
        ST_DIV: begin
          if (dv_done) begin
            sum_r <= sum_nxt;
            if (t_r == NW'(n_eff_r - 1'b1)) begin
              sum_sh_r <= SPAD_W'(sum_nxt);
              tgt_r    <= '0;
              mcnt_r   <= '0;
              state_r  <= ST_TGT;
            end else begin
              t_r     <= NW'(t_r + 1'b1);
              state_r <= ST_RD;
            end
          end
        end
        // draw threshold: fraction times total, digit-serial
        ST_TGT: begin
          tgt_r    <= TG_W'((tgt_r << DW16) +
                      TG_W'(frac_r * sum_sh_r[SPAD_W-1 -: DW16]));
          sum_sh_r <= SPAD_W'(sum_sh_r << DW16);
          mcnt_r   <= MC_W'(mcnt_r + 1'b1);
          if (mcnt_r == MC_W'(SND - 1)) begin
            s_r     <= '0;
            state_r <= ST_SRD;
          end
        end
        ST_SRD: state_r <= ST_SCMP;
        ST_SCMP: begin
          if (hit || s_r == NW'(n_eff_r - 1'b1)) begin
            res_r       <= s_r[TW-1:0];
            out_topic_r <= s_r[5:0] & 6'h3F;
            changed_r   <= moved;
            if (!moved) begin
              out_data_r  <= '{new_topic: 6'(s_r), topic_changed: 1'b0};
              out_valid_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else if (topic_ok_r) begin
              adj_topic_r <= TW'(topic_r);
              adj_inc_r   <= 1'b0;
              adj_wt_r    <= word_ok_r;
              adj_tt_r    <= 1'b1;
              adj_dc_r    <= 1'b1;
              adj_next_r  <= 1'b1;
              state_r     <= ST_ADJ_RD;
            end else begin
              adj_topic_r <= s_r[TW-1:0];
              adj_inc_r   <= 1'b1;
              adj_wt_r    <= word_ok_r;
              adj_tt_r    <= 1'b1;
              adj_dc_r    <= 1'b1;
              adj_next_r  <= 1'b0;
              state_r     <= ST_ADJ_RD;
            end
          end else begin
            s_r     <= NW'(s_r + 1'b1);
            state_r <= ST_SRD;
          end
        end
        ST_ADJ_RD: state_r <= ST_ADJ_WR;
        // write back; a pending increment of the new topic follows
        ST_ADJ_WR: begin
          if (adj_next_r) begin
            adj_topic_r <= res_r;
            adj_inc_r   <= 1'b1;
            adj_wt_r    <= word_ok_r;
            adj_tt_r    <= 1'b1;
            adj_dc_r    <= 1'b1;
            adj_next_r  <= 1'b0;
            state_r     <= ST_ADJ_RD;
          end else begin
            out_data_r  <= '{new_topic: out_topic_r, topic_changed: changed_r};
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  lgs_count_store #(
    .MAX_TOPICS (MAX_TOPICS),
    .VOCAB_SIZE (VOCAB_SIZE),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (st_ctrl),
    .wt_addr  (wt_addr),
    .tp_addr  (tp_addr),
    .wt_wdata (wt_wdata),
    .tt_wdata (tt_wdata),
    .dc_wdata (dc_wdata),
    .wt_rdata (wt_rdata),
    .tt_rdata (tt_rdata),
    .dc_rdata (dc_rdata),
    .clearing (clearing)
  );

  lgs_divider #(
    .NUM_W (PW),
    .DEN_W (CT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (state_r == ST_DGO),
    .num   (acc_r),
    .den   (ts_r),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("accepted transaction neither finished nor in progress");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(accept) || $past(state_r != ST_IDLE)))
    else $error("result with no transaction behind it");
  a_topic_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (t_r < n_eff_r))
    else $error("topic walk beyond active topics");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (state_r == ST_DIV))
    else $error("divider finished outside its wait state");
`endif

endmodule
